// ----- rtl/djs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djs_pkg: shared types for the deadline job sequencer
// Controller states and the command/status structs between control and data.
// ---------------------------------------------------------------------------
package djs_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SORT_RD,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_SORT_DONE,
        ST_SCHED_RD,
        ST_SCHED_WAIT,
        ST_SCHED_JOB,
        ST_SLOT_RD,
        ST_SLOT_WAIT,
        ST_SLOT_CHK,
        ST_RESULT
    } djs_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;         // accept input word
        logic clear_init;   // start slot clear sweep
        logic clear_step;   // clear one slot, advance
        logic sort_init;    // i = 0
        logic sort_start;   // k = i, j = i
        logic sort_rd;      // read order[j-1] and its job
        logic sort_shift;   // order[j] = order[j-1], j--
        logic sort_place;   // order[j] = k, i++
        logic sched_init;   // n = 0, clear sums
        logic sched_rd;     // read order[n]
        logic sched_job;    // latch job, set slot pointer
        logic slot_rd;      // read slot[s-1]
        logic slot_take;    // mark slot, add profit, n++
        logic slot_next;    // s--
        logic sched_skip;   // reject, n++
        logic finish;       // drive result, reset set
    } djs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic sort_all;     // i == count
        logic j_zero;
        logic k_first;      // job k goes before order[j-1]
        logic sched_all;    // n == count
        logic s_zero;
        logic slot_busy;
    } djs_stat_t;

endpackage

// ----- rtl/djs_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djs_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ---------------------------------------------------------------------------
module djs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/djs_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djs_datapath: job store, order buffer, slot map and accumulators
// Runs insertion sort and latest-free-slot search under controller command.
// ---------------------------------------------------------------------------
module djs_datapath #(
    parameter int MAX_JOBS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  djs_pkg::djs_cmd_t cmd,
    output djs_pkg::djs_stat_t stat,
    input  logic [15:0]       job_id,
    input  logic [15:0]       deadline,
    input  logic [15:0]       profit,
    output logic [10:0]       jobs_done,
    output logic [25:0]       total_profit,
    output logic              overflowed
);
    import djs_pkg::*;

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int JW = 48;
    localparam logic [10:0] DONE_MAX = 11'd2047;
    localparam logic [25:0] SUM_MAX  = 26'h3FFFFFF;

    // counters and pointers
    logic [CW-1:0] count_reg, i_reg, j_reg, n_reg, clr_reg;
    logic [16:0]   s_reg;
    logic          ovf_reg;
    logic [AW-1:0] k_reg;
    logic [JW-1:0] kjob_reg;     // job k, latched via kcap_reg after sort_start
    logic [15:0]   cur_profit_reg;
    logic [10:0]   done_reg;
    logic [25:0]   sum_reg;

    // memories
    logic          js_we, ob_we, sl_we, sl_wd, sl_rd;
    logic [AW-1:0] js_addr, ob_addr, sl_addr, ob_wd, ob_rd;
    logic [JW-1:0] js_wd, js_rd;

    djs_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_jobs
        (.clk(clk), .we(js_we), .addr(js_addr), .wdata(js_wd), .rdata(js_rd));
    djs_ram #(.WIDTH(AW), .DEPTH(MAX_JOBS)) u_order
        (.clk(clk), .we(ob_we), .addr(ob_addr), .wdata(ob_wd), .rdata(ob_rd));
    djs_ram #(.WIDTH(1), .DEPTH(MAX_JOBS)) u_slots
        (.clk(clk), .we(sl_we), .addr(sl_addr), .wdata(sl_wd), .rdata(sl_rd));

    // job word layout: {profit, id, deadline}
    logic [16:0] dl_clamp;
    logic        kb;
    always_comb
    begin
        js_we   = cmd.load && (count_reg < CW'(MAX_JOBS));
        js_wd   = {profit, job_id, deadline};
        js_addr = count_reg[AW-1:0];
        if (cmd.sort_start)
            js_addr = i_reg[AW-1:0];
        else if (cmd.sched_job || cmd.sched_rd || cmd.sort_rd)
            js_addr = ob_rd;
        ob_we   = cmd.sort_shift || cmd.sort_place;
        ob_wd   = cmd.sort_shift ? ob_rd : k_reg;
        ob_addr = cmd.sort_rd ? AW'(j_reg - 1'b1) :
                  cmd.sched_rd ? n_reg[AW-1:0] : j_reg[AW-1:0];
        sl_we   = cmd.clear_step || cmd.slot_take;
        sl_wd   = cmd.slot_take;
        sl_addr = cmd.clear_step ? clr_reg[AW-1:0] : AW'(s_reg - 1'b1);
        dl_clamp = (js_rd[15:0] > 16'(MAX_JOBS > 65535 ? 65535 : MAX_JOBS))
                   ? 17'(MAX_JOBS) : {1'b0, js_rd[15:0]};
        // k before other: profit, then id, then earlier index (k is newest)
        if (kjob_reg[47:32] != js_rd[47:32])
            kb = kjob_reg[47:32] > js_rd[47:32];
        else
            kb = kjob_reg[31:16] > js_rd[31:16];
    end

    // sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0; ovf_reg <= 1'b0;
            i_reg <= '0; j_reg <= '0; n_reg <= '0; clr_reg <= '0; s_reg <= '0;
            done_reg <= '0; sum_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (count_reg < CW'(MAX_JOBS))
                    count_reg <= count_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
            if (cmd.clear_init) clr_reg <= '0;
            if (cmd.clear_step) clr_reg <= clr_reg + 1'b1;
            if (cmd.sort_init)  i_reg <= '0;
            if (cmd.sort_start) j_reg <= i_reg;
            if (cmd.sort_shift) j_reg <= j_reg - 1'b1;
            if (cmd.sort_place) i_reg <= i_reg + 1'b1;
            if (cmd.sched_init)
            begin
                n_reg <= '0; done_reg <= '0; sum_reg <= '0;
            end
            if (cmd.sched_job)  s_reg <= dl_clamp;
            if (cmd.slot_next)  s_reg <= s_reg - 1'b1;
            if (cmd.sched_skip) n_reg <= n_reg + 1'b1;
            if (cmd.slot_take)
            begin
                n_reg <= n_reg + 1'b1;
                if (done_reg < DONE_MAX) done_reg <= done_reg + 1'b1;
                if ({1'b0, sum_reg} + 27'(cur_profit_reg) > 27'(SUM_MAX))
                    sum_reg <= SUM_MAX;
                else
                    sum_reg <= sum_reg + 26'(cur_profit_reg);
            end
            if (cmd.finish)
            begin
                count_reg <= '0; ovf_reg <= 1'b0;
            end
        end
    end

    // payload latches
    always_ff @(posedge clk)
    begin
        if (cmd.sort_start) k_reg <= i_reg[AW-1:0];
        if (cmd.sched_job) cur_profit_reg <= js_rd[47:32];
    end

    // job k word is read at sort_start; kcap_reg marks the following cycle to capture it
    logic kcap_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) kcap_reg <= 1'b0;
        else        kcap_reg <= cmd.sort_start;
    end
    always_ff @(posedge clk)
    begin
        if (kcap_reg) kjob_reg <= js_rd;
    end

    // status
    always_comb
    begin
        stat.clear_done  = (clr_reg == CW'(MAX_JOBS - 1));
        stat.sort_all    = (i_reg == count_reg);
        stat.j_zero      = (j_reg == '0);
        stat.k_first     = kb;
        stat.sched_all   = (n_reg == count_reg);
        stat.s_zero      = (s_reg == '0);
        stat.slot_busy   = sl_rd;
    end

    assign jobs_done    = done_reg;
    assign total_profit = sum_reg;
    assign overflowed   = ovf_reg;
endmodule

// ----- rtl/djs_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// djs_ctrl: sequencer state machine
// Load, clear slots, insertion sort, slot search, one result strobe.
// ---------------------------------------------------------------------------
module djs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               last,
    output logic               busy,
    output logic               done,
    output djs_pkg::djs_cmd_t  cmd,
    input  djs_pkg::djs_stat_t stat
);
    import djs_pkg::*;

    djs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= ST_LOAD;
        else        state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd  = '0;
        busy = (state_reg != ST_LOAD);
        done = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        cmd.clear_init = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    cmd.sort_init = 1'b1;
                    state_next = ST_SORT_RD;
                end
            end
            ST_SORT_RD:
            begin
                if (stat.sort_all)
                begin
                    cmd.sched_init = 1'b1;
                    state_next = ST_SCHED_RD;
                end
                else
                begin
                    cmd.sort_start = 1'b1;
                    state_next = ST_SORT_WAIT;
                end
            end
            ST_SORT_WAIT:
            begin
                // on entry from ST_SORT_RD job k word is captured this edge; now fetch order[j-1]
                if (stat.j_zero)
                    state_next = ST_SORT_DONE;
                else
                begin
                    cmd.sort_rd = 1'b1;
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                // order word valid; fetch its job, whose registered read lands in ST_SCHED_WAIT
                cmd.sort_rd = 1'b1;
                state_next = ST_SCHED_WAIT;
            end
            ST_SCHED_WAIT:
            begin
                if (stat.k_first)
                begin
                    cmd.sort_shift = 1'b1;
                    state_next = ST_SORT_WAIT;
                end
                else
                    state_next = ST_SORT_DONE;
            end
            ST_SORT_DONE:
            begin
                cmd.sort_place = 1'b1;
                state_next = ST_SORT_RD;
            end
            ST_SCHED_RD:
            begin
                if (stat.sched_all)
                    state_next = ST_RESULT;
                else
                begin
                    cmd.sched_rd = 1'b1;
                    state_next = ST_SCHED_JOB;
                end
            end
            ST_SCHED_JOB:
            begin
                // order word valid, fetch its job
                cmd.sched_rd = 1'b1;
                state_next = ST_SLOT_RD;
            end
            ST_SLOT_RD:
            begin
                cmd.sched_job = 1'b1;
                state_next = ST_SLOT_WAIT;
            end
            ST_SLOT_WAIT:
            begin
                if (stat.s_zero)
                begin
                    cmd.sched_skip = 1'b1;
                    state_next = ST_SCHED_RD;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    state_next = ST_SLOT_CHK;
                end
            end
            ST_SLOT_CHK:
            begin
                if (stat.slot_busy)
                begin
                    cmd.slot_next = 1'b1;
                    state_next = ST_SLOT_WAIT;
                end
                else
                begin
                    cmd.slot_take = 1'b1;
                    state_next = ST_SCHED_RD;
                end
            end
            ST_RESULT:
            begin
                done = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
    end
endmodule

// ----- rtl/deadline_job_sequencer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_job_sequencer: greedy job sequencing with deadlines
// Loads jobs one per cycle while idle, sorts by profit, places each in its latest free slot.
// ---------------------------------------------------------------------------
// Jobs load one per cycle while busy is low. After the word marked last the
// block goes busy: a clear of all MAX_JOBS slot-map entries, an insertion
// sort through the single-port order and job RAMs, then a search for the
// latest free slot of each job in sorted order. The result is shown for one
// cycle on done and the receiver must take it then.
module deadline_job_sequencer #(
    parameter int MAX_JOBS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] job_id,
    input  logic [15:0] deadline,
    input  logic [15:0] profit,
    input  logic        last,
    output logic        done,
    output logic [10:0] jobs_done,
    output logic [25:0] total_profit,
    output logic        overflowed
);
    import djs_pkg::*;

    djs_cmd_t  cmd;
    djs_stat_t stat;

    djs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last(last),
        .busy(busy), .done(done), .cmd(cmd), .stat(stat)
    );

    djs_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .job_id(job_id), .deadline(deadline), .profit(profit),
        .jobs_done(jobs_done), .total_profit(total_profit),
        .overflowed(overflowed)
    );

    // result strobe only after a busy run
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without busy");
    // run always ends with the block idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("still busy after result");
    // accepted last word starts a run
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last) |=> busy) else $error("run not started");
endmodule

// ----- tb/deadline_job_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_job_sequencer_tb: self-checking bench for the job sequencer
// Streams job sets into the block and predicts each set's scheduled count,
// total profit and overflow flag with a behavioral greedy scheduler.
// ---------------------------------------------------------------------------
module deadline_job_sequencer_tb;

    localparam int SLOTS      = 1024;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 4000;
    localparam int DONE_SAT   = 2047;
    localparam int SUM_SAT    = 67108863;

    typedef struct {
        logic [15:0] id;
        logic [15:0] dl;
        logic [15:0] pr;
    } job_t;

    typedef struct {
        job_t j;
        bit   lst;
        bit   hold;     // wait for all results before sending this word
        int   gap;      // idle cycles after this word
    } word_t;

    typedef struct {
        logic [10:0] n;
        logic [25:0] p;
        logic        o;
    } sched_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] job_id = '0;
    logic [15:0] deadline = '0;
    logic [15:0] profit = '0;
    logic        last = 1'b0;
    logic        done;
    logic [10:0] jobs_done;
    logic [25:0] total_profit;
    logic        overflowed;

    word_t      pending_words[$];
    sched_res_t expected_sched[$];
    job_t       set_jobs[$];
    bit         set_ovf = 1'b0;
    int         gap_left = 0;
    int         errors = 0;
    int         cycles = 0;
    bit         stim_ready = 1'b0;

    deadline_job_sequencer dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .job_id(job_id), .deadline(deadline), .profit(profit), .last(last),
        .done(done), .jobs_done(jobs_done), .total_profit(total_profit),
        .overflowed(overflowed)
    );

    always #1 clk = ~clk;

    // ordering rule: higher profit, then higher id, then earlier arrival
    function automatic bit ranks_ahead(int a, int b);
        if (set_jobs[a].pr != set_jobs[b].pr)
            return set_jobs[a].pr > set_jobs[b].pr;
        if (set_jobs[a].id != set_jobs[b].id)
            return set_jobs[a].id > set_jobs[b].id;
        return a < b;
    endfunction

    // greedy latest-free-slot schedule of the collected set
    function automatic sched_res_t schedule_set();
        int         ord[SLOTS];
        bit         taken[SLOTS];
        int         i, j, s, cnt, sum;
        bit         placed;
        sched_res_t r;
        cnt = 0;
        sum = 0;
        for (i = 0; i < SLOTS; i++)
            taken[i] = 1'b0;
        for (i = 0; i < set_jobs.size(); i++)
        begin
            j = i;
            while (j > 0 && ranks_ahead(i, ord[j-1]))
            begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
        for (i = 0; i < set_jobs.size(); i++)
        begin
            s = (set_jobs[ord[i]].dl > SLOTS) ? SLOTS : set_jobs[ord[i]].dl;
            placed = 1'b0;
            while (s > 0 && !placed)
            begin
                s--;
                if (!taken[s])
                begin
                    taken[s] = 1'b1;
                    placed = 1'b1;
                end
            end
            if (placed)
            begin
                if (cnt < DONE_SAT)
                    cnt++;
                sum += set_jobs[ord[i]].pr;
                if (sum > SUM_SAT)
                    sum = SUM_SAT;
            end
        end
        r.n = cnt[10:0];
        r.p = sum[25:0];
        r.o = set_ovf;
        return r;
    endfunction

    function automatic void add_word(logic [15:0] id, logic [15:0] dl, logic [15:0] pr,
                                     bit lst, bit hold, int gap);
        word_t w;
        w.j.id = id;
        w.j.dl = dl;
        w.j.pr = pr;
        w.lst = lst;
        w.hold = hold;
        w.gap = gap;
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic logic [15:0] rand_field(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 20));
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // build the stimulus
    initial
    begin
        int  n_rand, sz, k, dmode;
        bit  quiet;
        // directed: lone jobs at the field extremes
        add_word(16'h0000, 16'h0000, 16'hFFFF, 1, 0, 0);        // zero deadline
        add_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 2);        // deadline clamp
        add_word(16'h0001, 16'h0001, 16'h0000, 1, 0, 0);        // zero profit
        // profit ties broken by id, then by arrival
        add_word(16'h0005, 16'h0001, 16'h0010, 0, 1, 0);
        add_word(16'h0009, 16'h0001, 16'h0010, 0, 0, 0);
        add_word(16'h0009, 16'h0001, 16'h0010, 0, 0, 1);
        add_word(16'h0002, 16'h0002, 16'h0020, 1, 0, 0);
        // contention for early slots
        add_word(16'h0003, 16'h0002, 16'h0004, 0, 0, 0);
        add_word(16'h0004, 16'h0001, 16'h0008, 0, 0, 0);
        add_word(16'h0005, 16'h0002, 16'h000C, 0, 0, 0);
        add_word(16'h0006, 16'h0003, 16'h0001, 0, 0, 0);
        add_word(16'h0007, 16'h0000, 16'h7FFF, 1, 0, 0);
        // store overflow: already in order so the sort stays short
        for (k = 0; k < SLOTS + 6; k++)
            add_word(16'h00AA, (k < SLOTS) ? 16'(k + 1) : 16'hFFFF, 16'hFFFF,
                     (k == SLOTS + 5), (k == 0), 0);
        // random sets
        n_rand = 0;
        while (n_rand < 450)
        begin
            sz = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            quiet = ($urandom_range(0, 3) == 0);
            dmode = $urandom_range(0, 3);
            for (k = 0; k < sz; k++)
                add_word(rand_field($urandom_range(0, 3)),
                         (dmode == 3) ? 16'($urandom_range(0, sz + 1)) : rand_field(dmode),
                         rand_field($urandom_range(0, 3)),
                         (k == sz - 1), (k == 0 && $urandom_range(0, 7) == 0),
                         rand_gap(quiet));
            n_rand += sz;
        end
        stim_ready = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_words.size() == 0 && !start && expected_sched.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // driver: collect accepted word, then present the next one
    always @(posedge clk or negedge rst_n)
    begin : drv
        word_t w;
        bit    nstart;
        job_t  cj;
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
            // hold the word until the block takes it
        end
        else
        begin
            if (start)
            begin
                cj.id = job_id;
                cj.dl = deadline;
                cj.pr = profit;
                if (set_jobs.size() < SLOTS)
                    set_jobs.insert(set_jobs.size(), cj);
                else
                    set_ovf = 1'b1;
                if (last)
                begin
                    expected_sched.insert(expected_sched.size(), schedule_set());
                    set_jobs.delete();
                    set_ovf = 1'b0;
                end
            end
            nstart = 1'b0;
            if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (stim_ready && pending_words.size() > 0 &&
                     !(pending_words[0].hold && expected_sched.size() != 0))
            begin
                w = pending_words.pop_front();
                job_id <= w.j.id;
                deadline <= w.j.dl;
                profit <= w.j.pr;
                last <= w.lst;
                gap_left <= w.gap;
                nstart = 1'b1;
            end
            start <= nstart;
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge clk)
    begin : mon
        sched_res_t e;
        if (rst_n && done)
        begin
            if (expected_sched.size() == 0)
            begin
                $display("%0t: unexpected result n=%0d p=%0d o=%0d", $realtime,
                         jobs_done, total_profit, overflowed);
                errors++;
            end
            else
            begin
                e = expected_sched.pop_front();
                if (jobs_done !== e.n)
                begin
                    $display("%0t: jobs_done exp %0d got %0d", $realtime, e.n, jobs_done);
                    errors++;
                end
                if (total_profit !== e.p)
                begin
                    $display("%0t: total_profit exp %0d got %0d", $realtime, e.p,
                             total_profit);
                    errors++;
                end
                if (overflowed !== e.o)
                begin
                    $display("%0t: overflowed exp %0d got %0d", $realtime, e.o, overflowed);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// ----- files.f -----
rtl/djs_pkg.sv
rtl/djs_ram.sv
rtl/djs_datapath.sv
rtl/djs_ctrl.sv
rtl/deadline_job_sequencer.sv
tb/deadline_job_sequencer_tb.sv
